@@ src/aae_pkg.sv @@
// shared types, constants and helpers for the aizawa euler step datapath
package aae_pkg;

  localparam int unsigned FRAC_W = 24;
  localparam int unsigned CFG_IDX_W = 3;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_D    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_E    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_F    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd6;

  // reset values, q8.24
  localparam logic [31:0] RST_COEF_A    = 32'd15938355;
  localparam logic [31:0] RST_COEF_B    = 32'd11744051;
  localparam logic [31:0] RST_COEF_C    = 32'd10066330;
  localparam logic [31:0] RST_COEF_D    = 32'd58720256;
  localparam logic [31:0] RST_COEF_E    = 32'd4194304;
  localparam logic [31:0] RST_COEF_F    = 32'd1677722;
  localparam logic [30:0] RST_TIME_STEP = 31'd117441;

  localparam logic signed [63:0] HALF_Q   = 64'sd8388608;
  localparam logic signed [39:0] ONE_Q    = 40'sd16777216;
  localparam logic signed [39:0] S32_MAX  = 40'sd2147483647;
  localparam logic signed [39:0] S32_MIN  = -40'sd2147483648;

  // divide by three: offset keeps the dividend positive, floor(2^33/3) as reciprocal
  localparam logic signed [33:0] DIV3_OFS   = 34'sd3221225472;
  localparam logic [31:0]        DIV3_RECIP = 32'd2863311530;
  localparam logic [31:0]        DIV3_BIAS  = 32'h4000_0000;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } sat_t;

  typedef struct packed {
    logic [31:0] coef_a;
    logic [31:0] coef_b;
    logic [31:0] coef_c;
    logic [31:0] coef_d;
    logic [31:0] coef_e;
    logic [31:0] coef_f;
    logic [30:0] time_step;
  } coef_t;

  function automatic sat_t sat40(logic signed [39:0] v);
    sat_t r;
    if (v > S32_MAX) begin
      r.ovf = 1'b1;
      r.val = 32'h7fff_ffff;
    end else if (v < S32_MIN) begin
      r.ovf = 1'b1;
      r.val = 32'h8000_0000;
    end else begin
      r.ovf = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ src/aae_cfg.sv @@
// coefficient and step size registers with plain write port
module aae_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [aae_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_wdata_i,
  output aae_pkg::coef_t                coef_o
);

  aae_pkg::coef_t coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.coef_a    <= aae_pkg::RST_COEF_A;
      coef_q.coef_b    <= aae_pkg::RST_COEF_B;
      coef_q.coef_c    <= aae_pkg::RST_COEF_C;
      coef_q.coef_d    <= aae_pkg::RST_COEF_D;
      coef_q.coef_e    <= aae_pkg::RST_COEF_E;
      coef_q.coef_f    <= aae_pkg::RST_COEF_F;
      coef_q.time_step <= aae_pkg::RST_TIME_STEP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aae_pkg::REG_COEF_A:    coef_q.coef_a    <= cfg_wdata_i;
        aae_pkg::REG_COEF_B:    coef_q.coef_b    <= cfg_wdata_i;
        aae_pkg::REG_COEF_C:    coef_q.coef_c    <= cfg_wdata_i;
        aae_pkg::REG_COEF_D:    coef_q.coef_d    <= cfg_wdata_i;
        aae_pkg::REG_COEF_E:    coef_q.coef_e    <= cfg_wdata_i;
        aae_pkg::REG_COEF_F:    coef_q.coef_f    <= cfg_wdata_i;
        aae_pkg::REG_TIME_STEP: coef_q.time_step <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  assign coef_o = coef_q;

endmodule

@@ src/aae_mulq.sv @@
// registered q8.24 multiply with round to nearest and saturation
module aae_mulq (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [31:0] res_o,
  output logic               sat_o
);

  logic signed [63:0] prod;
  logic signed [63:0] rnd_full;
  logic signed [39:0] rnd;
  aae_pkg::sat_t      res_d;
  logic [31:0]        res_q;
  logic               sat_q;

  always_comb begin
    prod     = 64'(a_i) * 64'(b_i);
    rnd_full = (prod + aae_pkg::HALF_Q) >>> aae_pkg::FRAC_W;
    rnd      = rnd_full[39:0];
    res_d    = aae_pkg::sat40(rnd);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d.val;
      sat_q <= res_d.ovf;
    end
  end

  assign res_o = $signed(res_q);
  assign sat_o = sat_q;

endmodule

@@ src/aae_div3.sv @@
// two-stage floor((v+1)/3) by reciprocal multiply and one-step correction
module aae_div3 (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] val_i,
  output logic signed [31:0] third_o
);

  logic signed [33:0] ofs;
  logic [64:0]        prod;
  logic [32:0]        u_q;
  logic [31:0]        q0_q;
  logic [33:0]        three_q0;
  logic [2:0]         rem;
  logic [31:0]        third_d;
  logic [31:0]        third_q;

  // first stage: shift into positive range, estimate quotient (low by at most one)
  always_comb begin
    ofs  = 34'(val_i) + 34'sd1 + aae_pkg::DIV3_OFS;
    prod = 65'(ofs[32:0]) * 65'(aae_pkg::DIV3_RECIP);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q  <= ofs[32:0];
      q0_q <= prod[64:33];
    end
  end

  // second stage: remainder is in 0..5, so three low bits decide the correction
  always_comb begin
    three_q0 = {1'b0, q0_q, 1'b0} + 34'(q0_q);
    rem      = u_q[2:0] - three_q0[2:0];
    third_d  = q0_q + 32'((rem >= 3'd3) ? 1 : 0) - aae_pkg::DIV3_BIAS;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      third_q <= third_d;
    end
  end

  assign third_o = $signed(third_q);

endmodule

@@ src/aizawa_attractor_euler_step.sv @@
// aizawa attractor forward-euler step: 8-stage pipeline, one point per cycle unless the output is held
// throughput: one item per cycle while the output is not held; the longest chain is the z bracket
//   (z^3 via two multiplies, divide by three, sum, then the dt multiply)
// stall: all stages hold together while the output item waits
// reset: valid bits cleared, coefficients and time step load their defaults
module aizawa_attractor_euler_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [aae_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [31:0]            pos_x_i,
  input  logic signed [31:0]            pos_y_i,
  input  logic signed [31:0]            pos_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [31:0]            next_x_o,
  output logic signed [31:0]            next_y_o,
  output logic signed [31:0]            next_z_o,
  output logic                          overflow_o
);

  aae_pkg::coef_t coef;
  logic signed [31:0] coef_a, coef_b, coef_c, coef_d, coef_e, coef_f, tstep;

  logic       en;
  logic [7:0] vld_q;

  // stage 1
  aae_pkg::sat_t zb_d;
  logic signed [31:0] x1_q, y1_q, z1_q, zb1_q;
  logic ov1_q;

  // stage 2 products
  logic signed [31:0] zbx2, dyp2, dxp2, zby2, zz2, xx2, yy2, ez2, az2, fz2;
  logic s_zbx, s_dyp, s_dxp, s_zby, s_zz, s_xx, s_yy, s_ez, s_az, s_fz;
  logic signed [31:0] x2_q, y2_q, z2_q;
  logic ov2_q;

  // stage 3
  aae_pkg::sat_t bx_d, by_d, r2_d, ez1_d;
  logic signed [31:0] bx3_q, by3_q, r2_3_q, ez1_3_q, fz3_q, x3_q, y3_q, z3_q;
  logic signed [39:0] s3_q;
  logic ov3_q;
  logic signed [31:0] zc3, xc3;
  logic s_zc, s_xc;

  // stage 4
  logic signed [31:0] radial4, cub4, dx4, dy4, x4_q, y4_q, z4_q;
  logic s_rad, s_cub, s_dx, s_dy;
  logic signed [39:0] s4_q;
  logic ov4_q;

  // stage 5
  aae_pkg::sat_t nx_d, ny_d;
  logic signed [31:0] third5, nx5_q, ny5_q, z5_q;
  logic signed [39:0] t5_q;
  logic ov5_q;

  // stage 6
  aae_pkg::sat_t bz_d;
  logic signed [31:0] bz6_q, nx6_q, ny6_q, z6_q;
  logic ov6_q;

  // stage 7
  logic signed [31:0] dz7, nx7_q, ny7_q, z7_q;
  logic s_dz;
  logic ov7_q;

  // stage 8, output register
  aae_pkg::sat_t nz_d;
  logic [31:0] nx8_q, ny8_q, nz8_q;
  logic ov8_q;

  aae_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .coef_o     (coef)
  );

  assign coef_a = $signed(coef.coef_a);
  assign coef_b = $signed(coef.coef_b);
  assign coef_c = $signed(coef.coef_c);
  assign coef_d = $signed(coef.coef_d);
  assign coef_e = $signed(coef.coef_e);
  assign coef_f = $signed(coef.coef_f);
  assign tstep  = $signed({1'b0, coef.time_step});

  // whole pipe advances unless the output item is held
  assign en          = !vld_q[7] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[7];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[6:0], in_valid_i};
    end
  end

  // ---- stage 1: z - b
  assign zb_d = aae_pkg::sat40(40'(pos_z_i) - 40'(coef_b));

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q  <= pos_x_i;
      y1_q  <= pos_y_i;
      z1_q  <= pos_z_i;
      zb1_q <= $signed(zb_d.val);
      ov1_q <= zb_d.ovf;
    end
  end

  // ---- stage 2: first products
  aae_mulq u_m_zbx (.clk_i, .en_i(en), .a_i(zb1_q),  .b_i(x1_q), .res_o(zbx2), .sat_o(s_zbx));
  aae_mulq u_m_dyp (.clk_i, .en_i(en), .a_i(coef_d), .b_i(y1_q), .res_o(dyp2), .sat_o(s_dyp));
  aae_mulq u_m_dxp (.clk_i, .en_i(en), .a_i(coef_d), .b_i(x1_q), .res_o(dxp2), .sat_o(s_dxp));
  aae_mulq u_m_zby (.clk_i, .en_i(en), .a_i(zb1_q),  .b_i(y1_q), .res_o(zby2), .sat_o(s_zby));
  aae_mulq u_m_zz  (.clk_i, .en_i(en), .a_i(z1_q),   .b_i(z1_q), .res_o(zz2),  .sat_o(s_zz));
  aae_mulq u_m_xx  (.clk_i, .en_i(en), .a_i(x1_q),   .b_i(x1_q), .res_o(xx2),  .sat_o(s_xx));
  aae_mulq u_m_yy  (.clk_i, .en_i(en), .a_i(y1_q),   .b_i(y1_q), .res_o(yy2),  .sat_o(s_yy));
  aae_mulq u_m_ez  (.clk_i, .en_i(en), .a_i(coef_e), .b_i(z1_q), .res_o(ez2),  .sat_o(s_ez));
  aae_mulq u_m_az  (.clk_i, .en_i(en), .a_i(coef_a), .b_i(z1_q), .res_o(az2),  .sat_o(s_az));
  aae_mulq u_m_fz  (.clk_i, .en_i(en), .a_i(coef_f), .b_i(z1_q), .res_o(fz2),  .sat_o(s_fz));

  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_q  <= x1_q;
      y2_q  <= y1_q;
      z2_q  <= z1_q;
      ov2_q <= ov1_q;
    end
  end

  // ---- stage 3: brackets of dx and dy, x^2+y^2, 1+ez, cubes
  assign bx_d  = aae_pkg::sat40(40'(zbx2) - 40'(dyp2));
  assign by_d  = aae_pkg::sat40(40'(dxp2) + 40'(zby2));
  assign r2_d  = aae_pkg::sat40(40'(xx2) + 40'(yy2));
  assign ez1_d = aae_pkg::sat40(aae_pkg::ONE_Q + 40'(ez2));

  aae_mulq u_m_zc (.clk_i, .en_i(en), .a_i(zz2), .b_i(z2_q), .res_o(zc3), .sat_o(s_zc));
  aae_mulq u_m_xc (.clk_i, .en_i(en), .a_i(xx2), .b_i(x2_q), .res_o(xc3), .sat_o(s_xc));

  always_ff @(posedge clk_i) begin
    if (en) begin
      bx3_q   <= $signed(bx_d.val);
      by3_q   <= $signed(by_d.val);
      r2_3_q  <= $signed(r2_d.val);
      ez1_3_q <= $signed(ez1_d.val);
      s3_q    <= 40'(coef_c) + 40'(az2);
      fz3_q   <= fz2;
      x3_q    <= x2_q;
      y3_q    <= y2_q;
      z3_q    <= z2_q;
      ov3_q   <= ov2_q | s_zbx | s_dyp | s_dxp | s_zby | s_zz | s_xx | s_yy | s_ez
               | s_az | s_fz | bx_d.ovf | by_d.ovf | r2_d.ovf | ez1_d.ovf;
    end
  end

  // ---- stage 4: radial and cubic terms, dx and dy, divide by three starts
  aae_mulq u_m_rad (.clk_i, .en_i(en), .a_i(r2_3_q), .b_i(ez1_3_q), .res_o(radial4), .sat_o(s_rad));
  aae_mulq u_m_cub (.clk_i, .en_i(en), .a_i(fz3_q),  .b_i(xc3),     .res_o(cub4),    .sat_o(s_cub));
  aae_mulq u_m_dx  (.clk_i, .en_i(en), .a_i(bx3_q),  .b_i(tstep),   .res_o(dx4),     .sat_o(s_dx));
  aae_mulq u_m_dy  (.clk_i, .en_i(en), .a_i(by3_q),  .b_i(tstep),   .res_o(dy4),     .sat_o(s_dy));

  aae_div3 u_div3 (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  (zc3),
    .third_o(third5)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q  <= s3_q;
      x4_q  <= x3_q;
      y4_q  <= y3_q;
      z4_q  <= z3_q;
      ov4_q <= ov3_q | s_zc | s_xc;
    end
  end

  // ---- stage 5: partial z bracket, next x and y
  assign nx_d = aae_pkg::sat40(40'(x4_q) + 40'(dx4));
  assign ny_d = aae_pkg::sat40(40'(y4_q) + 40'(dy4));

  always_ff @(posedge clk_i) begin
    if (en) begin
      t5_q  <= s4_q - 40'(radial4) + 40'(cub4);
      nx5_q <= $signed(nx_d.val);
      ny5_q <= $signed(ny_d.val);
      z5_q  <= z4_q;
      ov5_q <= ov4_q | s_rad | s_cub | s_dx | s_dy | nx_d.ovf | ny_d.ovf;
    end
  end

  // ---- stage 6: z bracket
  assign bz_d = aae_pkg::sat40(t5_q - 40'(third5));

  always_ff @(posedge clk_i) begin
    if (en) begin
      bz6_q <= $signed(bz_d.val);
      nx6_q <= nx5_q;
      ny6_q <= ny5_q;
      z6_q  <= z5_q;
      ov6_q <= ov5_q | bz_d.ovf;
    end
  end

  // ---- stage 7: dz
  aae_mulq u_m_dz (.clk_i, .en_i(en), .a_i(bz6_q), .b_i(tstep), .res_o(dz7), .sat_o(s_dz));

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx7_q <= nx6_q;
      ny7_q <= ny6_q;
      z7_q  <= z6_q;
      ov7_q <= ov6_q;
    end
  end

  // ---- stage 8: next z, output register
  assign nz_d = aae_pkg::sat40(40'(z7_q) + 40'(dz7));

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx8_q <= nx7_q;
      ny8_q <= ny7_q;
      nz8_q <= nz_d.val;
      ov8_q <= ov7_q | s_dz | nz_d.ovf;
    end
  end

  assign next_x_o   = $signed(nx8_q);
  assign next_y_o   = $signed(ny8_q);
  assign next_z_o   = $signed(nz8_q);
  assign overflow_o = ov8_q;

endmodule

@@ bench/aizawa_attractor_euler_step_tb.sv @@
// self-checking bench for the aizawa euler step: corner and random points, several coef sets
`timescale 1ns / 1ps

module aizawa_attractor_euler_step_tb;

  localparam int ITEMS_PER_PHASE = 200;
  localparam int NUM_PHASES      = 8;
  localparam int MAX_GAP         = 17;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 16;
  localparam logic [aae_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        ovf;
  } step_res_t;

  class step_checker;
    localparam longint Q_ONE  = 64'sd16777216;
    localparam longint Q_HALF = 64'sd8388608;
    localparam longint LIM_HI = 64'sd2147483647;
    localparam longint LIM_LO = -64'sd2147483648;

    longint ca, cb, cc, cd, ce, cf, dt;
    bit clipped;
    step_res_t expected_steps[$];
    int mismatches;

    function new();
      ca = longint'($signed(aae_pkg::RST_COEF_A));
      cb = longint'($signed(aae_pkg::RST_COEF_B));
      cc = longint'($signed(aae_pkg::RST_COEF_C));
      cd = longint'($signed(aae_pkg::RST_COEF_D));
      ce = longint'($signed(aae_pkg::RST_COEF_E));
      cf = longint'($signed(aae_pkg::RST_COEF_F));
      dt = longint'({1'b0, aae_pkg::RST_TIME_STEP});
      mismatches = 0;
    endfunction

    function void write_reg(logic [aae_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
      case (idx)
        aae_pkg::REG_COEF_A:    ca = longint'($signed(d));
        aae_pkg::REG_COEF_B:    cb = longint'($signed(d));
        aae_pkg::REG_COEF_C:    cc = longint'($signed(d));
        aae_pkg::REG_COEF_D:    cd = longint'($signed(d));
        aae_pkg::REG_COEF_E:    ce = longint'($signed(d));
        aae_pkg::REG_COEF_F:    cf = longint'($signed(d));
        aae_pkg::REG_TIME_STEP: dt = longint'({1'b0, d[30:0]});
        default: ;
      endcase
    endfunction

    function longint clip(longint v);
      if (v > LIM_HI) begin
        clipped = 1'b1;
        return LIM_HI;
      end
      if (v < LIM_LO) begin
        clipped = 1'b1;
        return LIM_LO;
      end
      return v;
    endfunction

    // round to nearest, ties up, via arithmetic shift (floor)
    function longint qmul(longint p, longint q);
      return clip((p * q + Q_HALF) >>> 24);
    endfunction

    function longint third_near(longint v);
      longint t, q;
      t = v + 1;
      q = t / 3;
      if (t < 0 && q * 3 != t) q = q - 1;
      return q;
    endfunction

    function void note_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      longint x, y, z, zb, bx, by, bz, z3, r2, ez1, radial, x3, cub;
      step_res_t r;
      x = longint'($signed(px));
      y = longint'($signed(py));
      z = longint'($signed(pz));
      clipped = 1'b0;
      zb = clip(z - cb);
      bx = clip(qmul(zb, x) - qmul(cd, y));
      by = clip(qmul(cd, x) + qmul(zb, y));
      z3 = qmul(qmul(z, z), z);
      r2 = clip(qmul(x, x) + qmul(y, y));
      ez1 = clip(Q_ONE + qmul(ce, z));
      radial = qmul(r2, ez1);
      x3 = qmul(qmul(x, x), x);
      cub = qmul(qmul(cf, z), x3);
      bz = clip(cc + qmul(ca, z) - third_near(z3) - radial + cub);
      r.x = 32'(clip(x + qmul(bx, dt)));
      r.y = 32'(clip(y + qmul(by, dt)));
      r.z = 32'(clip(z + qmul(bz, dt)));
      r.ovf = clipped;
      expected_steps = {expected_steps, r};
    endfunction

    function void check_step(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz, logic ovf);
      step_res_t want;
      if (expected_steps.size() == 0) begin
        $error("result with no pending point: %h %h %h %b", nx, ny, nz, ovf);
        mismatches++;
        return;
      end
      want = expected_steps.pop_front();
      if (nx !== want.x) begin
        $error("next_x: expected %h, got %h", want.x, nx);
        mismatches++;
      end
      if (ny !== want.y) begin
        $error("next_y: expected %h, got %h", want.y, ny);
        mismatches++;
      end
      if (nz !== want.z) begin
        $error("next_z: expected %h, got %h", want.z, nz);
        mismatches++;
      end
      if (ovf !== want.ovf) begin
        $error("overflow: expected %b, got %b", want.ovf, ovf);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_steps.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [aae_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [31:0]                   cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic signed [31:0]            pos_x_i;
  logic signed [31:0]            pos_y_i;
  logic signed [31:0]            pos_z_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic signed [31:0]            next_x_o;
  logic signed [31:0]            next_y_o;
  logic signed [31:0]            next_z_o;
  logic                          overflow_o;

  step_checker sb = new();
  bit send_idle;
  bit recv_idle;
  bit hold_req;

  aizawa_attractor_euler_step dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .next_x_o    (next_x_o),
    .next_y_o    (next_y_o),
    .next_z_o    (next_z_o),
    .overflow_o  (overflow_o)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // sample handshakes and register writes at the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i === 1'b1) sb.write_reg(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i === 1'b1 && in_ready_o === 1'b1) sb.note_point(pos_x_i, pos_y_i, pos_z_i);
      if (out_valid_o === 1'b1 && out_ready_i === 1'b1)
        sb.check_step(next_x_o, next_y_o, next_z_o, overflow_o);
    end
  end

  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = $urandom_range(0, 2 ** 26) - 2 ** 25;
      6:       v = $urandom;
      7: begin
        case ($urandom_range(0, 5))
          0: v = 32'h7fff_ffff;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          3: v = 32'h0000_0001;
          4: v = 32'hffff_ffff;
          default: v = 32'h0100_0000;
        endcase
      end
      default: v = $urandom_range(0, 2 ** 29) - 2 ** 28;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_coef();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $urandom_range(0, 2 ** 27) - 2 ** 26;
  endfunction

  task automatic send_point(input point_t p);
    int gap;
    gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= p.x;
    pos_y_i <= p.y;
    pos_z_i <= p.z;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  // sender stops and waits for the pipe to empty
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [aae_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= d;
    @(posedge clk_i);
  endtask

  task automatic program_coefs(input int phase);
    case (phase)
      0: begin
        set_reg(REG_UNUSED, $urandom);
        // top bit lies above the 31-bit step register
        set_reg(aae_pkg::REG_TIME_STEP, {1'b1, aae_pkg::RST_TIME_STEP});
      end
      1: begin
        for (logic [aae_pkg::CFG_IDX_W-1:0] i = aae_pkg::REG_COEF_A;
             i <= aae_pkg::REG_COEF_F; i++) set_reg(i, 32'h7fff_ffff);
        set_reg(aae_pkg::REG_TIME_STEP, 32'hffff_ffff);
      end
      2: begin
        for (logic [aae_pkg::CFG_IDX_W-1:0] i = aae_pkg::REG_COEF_A;
             i <= aae_pkg::REG_COEF_F; i++) set_reg(i, 32'h8000_0000);
        set_reg(aae_pkg::REG_TIME_STEP, 32'h0000_0000);
      end
      3: begin
        set_reg(aae_pkg::REG_COEF_A, aae_pkg::RST_COEF_A);
        set_reg(aae_pkg::REG_COEF_B, aae_pkg::RST_COEF_B);
        set_reg(aae_pkg::REG_COEF_C, aae_pkg::RST_COEF_C);
        set_reg(aae_pkg::REG_COEF_D, aae_pkg::RST_COEF_D);
        set_reg(aae_pkg::REG_COEF_E, aae_pkg::RST_COEF_E);
        set_reg(aae_pkg::REG_COEF_F, aae_pkg::RST_COEF_F);
        set_reg(aae_pkg::REG_TIME_STEP, 32'h0100_0000);
      end
      default: begin
        for (logic [aae_pkg::CFG_IDX_W-1:0] i = aae_pkg::REG_COEF_A;
             i <= aae_pkg::REG_COEF_F; i++) set_reg(i, rand_coef());
        if ($urandom_range(0, 3) == 0) set_reg(aae_pkg::REG_TIME_STEP, $urandom);
        else set_reg(aae_pkg::REG_TIME_STEP,
                     {1'($urandom_range(0, 1)), 31'($urandom_range(0, 2 ** 24))});
        if ($urandom_range(0, 1) == 0) set_reg(REG_UNUSED, $urandom);
      end
    endcase
    cfg_we_i <= 1'b0;
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        stall = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  initial begin
    point_t corner_pts [17];
    point_t p;

    corner_pts = '{
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
      '{32'h0100_0000, 32'h0000_0000, 32'h0000_0000},
      '{32'h0019_999a, 32'h0000_0000, 32'h0000_0000},
      '{32'h0080_0000, 32'hffb3_3334, 32'h00b3_3333},  // z equals b
      '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
      '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff},
      '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000},
      '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff},
      '{32'h0000_0001, 32'h0000_0001, 32'h0000_0001},
      '{32'h0000_0000, 32'h0000_0000, 32'h0300_0000},
      '{32'h0000_0000, 32'h0000_0000, 32'hfe00_0000},
      '{32'h0800_0000, 32'h0000_0000, 32'h0000_0000},  // x^3 clips inside
      '{32'h0000_0000, 32'h0c00_0000, 32'h0000_0000},  // x^2+y^2 clips
      '{32'h0000_0000, 32'h0000_0000, 32'h0600_0000},  // z^3 clips
      '{32'hfe80_0000, 32'h0180_0000, 32'hfe80_0000},
      '{32'h0080_0000, 32'h0000_0001, 32'hffff_ffff}   // rounding ties
    };
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = aae_pkg::REG_COEF_A;
    cfg_wdata_i = 32'h0;
    in_valid_i = 1'b0;
    pos_x_i = 32'sh0;
    pos_y_i = 32'sh0;
    pos_z_i = 32'sh0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    hold_req = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_pts[i]) send_point(corner_pts[i]);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      program_coefs(ph);
      // receiver stops for a long stretch while points keep coming
      if (ph == 3) hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 25 == 0) begin
          send_idle = ($urandom_range(0, 2) != 0);
          recv_idle = ($urandom_range(0, 2) != 0);
        end
        p.x = rand_coord();
        p.y = rand_coord();
        p.z = rand_coord();
        send_point(p);
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
src/aae_pkg.sv
src/aae_cfg.sv
src/aae_mulq.sv
src/aae_div3.sv
src/aizawa_attractor_euler_step.sv
bench/aizawa_attractor_euler_step_tb.sv
